// ----- hdl/bssp_pkg.sv -----
package bssp_pkg;

  // Suffix storage
  localparam int unsigned MAX_SUFFIX_CHARS = 3;
  localparam int unsigned SFX_IDX_W = $clog2(MAX_SUFFIX_CHARS);
  localparam int unsigned SFX_LEN_W = $clog2(MAX_SUFFIX_CHARS + 2);

  // Value range
  localparam int unsigned VALUE_W = 63;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Scaling: every unit is a power of 1000 or of 1024, up to the fourth
  localparam int unsigned NUM_SCALE_STAGES = 4;
  localparam int unsigned STEPS_W = 3;
  localparam int unsigned SCALE_SHIFT = 10;

  // Lower-case characters of the unit names
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_K = 8'h6B;
  localparam logic [7:0] CHAR_M = 8'h6D;
  localparam logic [7:0] CHAR_G = 8'h67;
  localparam logic [7:0] CHAR_T = 8'h74;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PUNCT    = 2'd1,
    ST_UNIT     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] byte_count;
    status_e            status;
  } out_item_t;

  // One parsed string on its way through the scaling stages
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
    logic               punct;
    logic               unit_bad;
    logic [STEPS_W-1:0] steps;
    logic               binary;
  } job_t;

  // Apply status priority and zero the count on any error
  function automatic out_item_t to_result(input job_t job);
    out_item_t res;
    res.byte_count = '0;
    if (job.punct) begin
      res.status = ST_PUNCT;
    end else if (job.unit_bad) begin
      res.status = ST_UNIT;
    end else if (job.overflow) begin
      res.status = ST_OVERFLOW;
    end else begin
      res.status = ST_OK;
      res.byte_count = job.value;
    end
    return res;
  endfunction

endpackage

// ----- hdl/bssp_accum.sv -----
module bssp_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bssp_pkg::in_item_t in_data_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output bssp_pkg::job_t     job_o
);

  logic [bssp_pkg::VALUE_W-1:0]   val_q, val_d;
  logic                           in_sfx_q, in_sfx_d;
  logic [7:0]                     chars_q [bssp_pkg::MAX_SUFFIX_CHARS];
  logic [7:0]                     chars_d [bssp_pkg::MAX_SUFFIX_CHARS];
  logic [bssp_pkg::SFX_LEN_W-1:0] len_q, len_d;
  logic                           punct_q, punct_d;
  logic                           ovf_q, ovf_d;
  logic                           job_valid_q;
  bssp_pkg::job_t                 job_q, job_d;
  logic                           accept;
  logic [bssp_pkg::VALUE_W+3:0]   wide;

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Decimal prefix letter to number of scaling steps; zero means no match
  function automatic logic [bssp_pkg::STEPS_W-1:0] prefix_steps(input logic [7:0] c);
    logic [bssp_pkg::STEPS_W-1:0] s;
    case (c)
      bssp_pkg::CHAR_K: s = bssp_pkg::STEPS_W'(1);
      bssp_pkg::CHAR_M: s = bssp_pkg::STEPS_W'(2);
      bssp_pkg::CHAR_G: s = bssp_pkg::STEPS_W'(3);
      bssp_pkg::CHAR_T: s = bssp_pkg::STEPS_W'(4);
      default:          s = '0;
    endcase
    return s;
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !job_valid_q || job_ready_i;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  // Fold the character into the running state
  always_comb begin
    logic [7:0]                   c;
    logic [7:0]                   lc0, lc1, lc2;
    logic [bssp_pkg::STEPS_W-1:0] ps;
    c        = in_data_i.char_code;
    val_d    = val_q;
    in_sfx_d = in_sfx_q;
    chars_d  = chars_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    punct_d  = punct_q | is_punct(c);
    wide     = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1) +
               (bssp_pkg::VALUE_W + 4)'(c[3:0]);

    if (!in_sfx_q && c >= 8'h30 && c <= 8'h39) begin
      if (|wide[bssp_pkg::VALUE_W+3:bssp_pkg::VALUE_W]) begin
        val_d = bssp_pkg::VALUE_MAX;
        ovf_d = 1'b1;
      end else begin
        val_d = wide[bssp_pkg::VALUE_W-1:0];
      end
    end else begin
      in_sfx_d = 1'b1;
      if (len_q < bssp_pkg::SFX_LEN_W'(bssp_pkg::MAX_SUFFIX_CHARS)) begin
        chars_d[len_q[bssp_pkg::SFX_IDX_W-1:0]] = c;
      end
      if (len_q <= bssp_pkg::SFX_LEN_W'(bssp_pkg::MAX_SUFFIX_CHARS)) begin
        len_d = len_q + 1'b1;
      end
    end

    // Match the suffix as it stands after this character
    lc0 = to_lower(chars_d[0]);
    lc1 = to_lower(chars_d[1]);
    lc2 = to_lower(chars_d[2]);
    ps  = prefix_steps(lc0);

    job_d.value    = val_d;
    job_d.overflow = ovf_d;
    job_d.punct    = punct_d;
    job_d.unit_bad = 1'b1;
    job_d.steps    = '0;
    job_d.binary   = 1'b0;
    if (len_d == bssp_pkg::SFX_LEN_W'(0)) begin
      job_d.unit_bad = 1'b0;
    end else if (len_d == bssp_pkg::SFX_LEN_W'(1)) begin
      job_d.unit_bad = (lc0 != bssp_pkg::CHAR_B);
    end else if (len_d == bssp_pkg::SFX_LEN_W'(2)) begin
      job_d.unit_bad = (ps == '0) || (lc1 != bssp_pkg::CHAR_B);
      job_d.steps    = ps;
    end else if (len_d == bssp_pkg::SFX_LEN_W'(3)) begin
      job_d.unit_bad = (ps == '0) || (lc1 != bssp_pkg::CHAR_I) ||
                       (lc2 != bssp_pkg::CHAR_B);
      job_d.steps    = ps;
      job_d.binary   = 1'b1;
    end
  end

  // Hold string state; clear it after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q    <= '0;
      in_sfx_q <= 1'b0;
      len_q    <= '0;
      punct_q  <= 1'b0;
      ovf_q    <= 1'b0;
      for (int i = 0; i < bssp_pkg::MAX_SUFFIX_CHARS; i++) begin
        chars_q[i] <= '0;
      end
    end else if (accept) begin
      if (in_data_i.is_last) begin
        val_q    <= '0;
        in_sfx_q <= 1'b0;
        len_q    <= '0;
        punct_q  <= 1'b0;
        ovf_q    <= 1'b0;
        for (int i = 0; i < bssp_pkg::MAX_SUFFIX_CHARS; i++) begin
          chars_q[i] <= '0;
        end
      end else begin
        val_q    <= val_d;
        in_sfx_q <= in_sfx_d;
        len_q    <= len_d;
        punct_q  <= punct_d;
        ovf_q    <= ovf_d;
        chars_q  <= chars_d;
      end
    end
  end

  // Launch a job on the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (accept && in_data_i.is_last) begin
      job_valid_q <= 1'b1;
    end else if (job_ready_i) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.is_last) begin
      job_q <= job_d;
    end
  end

endmodule

// ----- hdl/bssp_scale.sv -----
module bssp_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bssp_pkg::job_t in_job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bssp_pkg::job_t out_job_o
);

  localparam int unsigned ProdW = bssp_pkg::VALUE_W + bssp_pkg::SCALE_SHIFT;

  logic           valid_q;
  bssp_pkg::job_t job_q, job_d;
  logic [ProdW-1:0] ext;
  logic [ProdW-1:0] prod;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_job_o   = job_q;

  // Multiply by 1024 or by 1000 (1024 - 16 - 8) and flag a carry past 63 bits
  always_comb begin
    ext   = {{bssp_pkg::SCALE_SHIFT{1'b0}}, in_job_i.value};
    job_d = in_job_i;
    if (in_job_i.binary) begin
      prod = ext << bssp_pkg::SCALE_SHIFT;
    end else begin
      prod = (ext << bssp_pkg::SCALE_SHIFT) - (ext << 4) - (ext << 3);
    end
    if (in_job_i.steps != '0 && !in_job_i.overflow) begin
      job_d.steps = in_job_i.steps - 1'b1;
      if (|prod[ProdW-1:bssp_pkg::VALUE_W]) begin
        job_d.overflow = 1'b1;
        job_d.value    = bssp_pkg::VALUE_MAX;
      end else begin
        job_d.value = prod[bssp_pkg::VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      job_q <= job_d;
    end
  end

endmodule

// ----- hdl/byte_size_string_parser_top.sv -----
// A result passes through the match register, then four x1000/x1024 scaling
// stages, before it is offered.
// Throughput: one character per cycle while the output is not stalled;
// results stream back to back.
// Characters other than the last produce no result.
// Reset (rst_ni low, asynchronous) clears the string state and all stages.
module byte_size_string_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bssp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bssp_pkg::out_item_t out_data_o
);

  localparam int unsigned NumSt = bssp_pkg::NUM_SCALE_STAGES;

  logic           valid [NumSt+1];
  logic           ready [NumSt+1];
  bssp_pkg::job_t job   [NumSt+1];

  // Accumulate digits and suffix, match the unit
  bssp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (valid[0]),
    .job_ready_i (ready[0]),
    .job_o       (job[0])
  );

  // Scale by the unit factor, one step of 1000 or 1024 per stage
  for (genvar s = 0; s < NumSt; s++) begin : g_scale
    bssp_scale u_scale (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[s]),
      .in_ready_o  (ready[s]),
      .in_job_i    (job[s]),
      .out_valid_o (valid[s+1]),
      .out_ready_i (ready[s+1]),
      .out_job_o   (job[s+1])
    );
  end

  // Last stage holds the result for transfer
  assign ready[NumSt] = out_ready_i;
  assign out_valid_o  = valid[NumSt];
  assign out_data_o   = bssp_pkg::to_result(job[NumSt]);

endmodule

// ----- hdl/bssp_checker.sv -----
module bssp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bssp_pkg::out_item_t out_data_o
);

  // No result is offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Errors carry a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bssp_pkg::ST_OK |->
      out_data_o.byte_count == '0)
    else $error("nonzero count with error status");

  // Input backpressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind byte_size_string_parser_top bssp_checker u_bssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
